[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Each expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/bsme_pkg.sv]
// ----------------------------------------------------------------------------
// bsme_pkg
// Types, codes and defaults for the byte stack machine executor.
// ----------------------------------------------------------------------------
`default_nettype none
package bsme_pkg;

  localparam int PC_W = 21;
  localparam int DATA_MEM_BYTES = 256;
  localparam int STACK_DEPTH_DEF = 65536;
  localparam int CALL_DEPTH_DEF = 8192;
  localparam int CODE_LIMIT_DEF = 1048576;
  localparam logic [31:0] STEPS_RESET = 32'd5000000;

  // configuration register indexes
  localparam logic [7:0] REG_CODE_LENGTH = 8'd0;
  localparam logic [7:0] REG_MAX_STEPS = 8'd1;

  // status codes
  localparam logic [3:0] ST_RUN = 4'd0;
  localparam logic [3:0] ST_HALT = 4'd1;
  localparam logic [3:0] ST_STEPS = 4'd2;
  localparam logic [3:0] ST_PC = 4'd3;
  localparam logic [3:0] ST_OPND = 4'd4;
  localparam logic [3:0] ST_OVF = 4'd5;
  localparam logic [3:0] ST_UNF = 4'd6;
  localparam logic [3:0] ST_COVF = 4'd7;
  localparam logic [3:0] ST_RUNF = 4'd8;
  localparam logic [3:0] ST_INPUT = 4'd9;
  localparam logic [3:0] ST_BADOP = 4'd10;

  // opcodes
  localparam logic [7:0] OP_HALT = 8'd0;
  localparam logic [7:0] OP_PUSH = 8'd1;
  localparam logic [7:0] OP_DROP = 8'd2;
  localparam logic [7:0] OP_ADD = 8'd3;
  localparam logic [7:0] OP_SUB = 8'd4;
  localparam logic [7:0] OP_LOAD = 8'd5;
  localparam logic [7:0] OP_STORE = 8'd6;
  localparam logic [7:0] OP_JMP = 8'd7;
  localparam logic [7:0] OP_BZ = 8'd8;
  localparam logic [7:0] OP_CALL = 8'd9;
  localparam logic [7:0] OP_RET = 8'd10;
  localparam logic [7:0] OP_IN = 8'd11;
  localparam logic [7:0] OP_OUT = 8'd12;
  localparam logic [7:0] OP_DUP = 8'd13;
  localparam logic [7:0] OP_EQ = 8'd14;
  localparam logic [7:0] OP_LT = 8'd15;
  localparam logic [7:0] OP_AND = 8'd16;
  localparam logic [7:0] OP_OR = 8'd17;
  localparam logic [7:0] OP_XOR = 8'd18;
  localparam logic [7:0] OP_DROP2 = 8'd19;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand;
    logic [7:0] in_byte;
    logic       in_valid;
  } item_t;

  typedef struct packed {
    logic [3:0]      status;
    logic [PC_W-1:0] next_pc;
    logic            out_valid;
    logic [7:0]      out_byte;
    logic            input_taken;
    logic            stopped;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/bsme_out_fifo.sv]
// ----------------------------------------------------------------------------
// bsme_out_fifo
// Two-entry result queue so the executor keeps going while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
module bsme_out_fifo (
  input  wire               clk,
  input  wire               rst,
  input  wire               wr,
  input  bsme_pkg::result_t din,
  output logic              full,
  output logic              res_valid,
  input  wire               res_stall,
  output bsme_pkg::result_t res
);

  bsme_pkg::result_t q0, q1;
  logic [1:0] cnt;
  logic pop;

  assign pop = (cnt != 2'd0) && !res_stall;
  assign full = (cnt == 2'd2);
  assign res_valid = (cnt != 2'd0);
  assign res = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, wr} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && wr) begin
      if (cnt == 2'd1) begin
        q0 <= din;
      end else begin
        q0 <= q1;
        q1 <= din;
      end
    end else if (pop) begin
      q0 <= q1;
    end else if (wr) begin
      if (cnt == 2'd0) q0 <= din;
      else q1 <= din;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/byte_stack_machine_executor_unit.sv]
// ----------------------------------------------------------------------------
// byte_stack_machine_executor_unit
// Byte stack machine executor: one instruction per accepted item. The top
// two data stack bytes and the top return address live in registers, the
// rest in synchronous RAMs. An instruction that pops the data stack (drop,
// out, branch, binary ops) holds the input while the cached second entry
// refills from RAM, a load while its data memory read completes, a return
// while a deeper return address refills, and a store while the top and
// then the second entry refill; no refill is made that the stacks are too
// shallow to need. Each result enters a two-entry output buffer when its
// item is accepted; the input stalls in a refill, while the buffer is full
// and in reset. No clearing pass: data memory uses one valid bit per byte.
// ----------------------------------------------------------------------------
`default_nettype none
module byte_stack_machine_executor_unit #(
  parameter int STACK_DEPTH = bsme_pkg::STACK_DEPTH_DEF,
  parameter int CALL_DEPTH  = bsme_pkg::CALL_DEPTH_DEF,
  parameter int CODE_LIMIT  = bsme_pkg::CODE_LIMIT_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  output logic                   item_stall,
  input  bsme_pkg::item_t        item,
  output logic                   res_valid,
  input  wire                    res_stall,
  output bsme_pkg::result_t      res,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [7:0]             cfg_index,
  input  wire  [31:0]            cfg_data
);

  localparam int PW  = bsme_pkg::PC_W;
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int RCW = $clog2(CALL_DEPTH + 1);
  localparam int RAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam logic [PW-1:0] LIMIT = PW'(CODE_LIMIT);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_NOS  = 3'd1;
  localparam logic [2:0] F_TOS  = 3'd2;
  localparam logic [2:0] F_LOAD = 3'd3;
  localparam logic [2:0] F_RET  = 3'd4;

  // architectural state
  logic [PW-1:0]  code_size;
  logic [31:0]    step_budget;
  logic [SCW-1:0] sc, sc_next;
  logic [7:0]     tos, tos_next, nos, nos_next;
  logic [RCW-1:0] rc, rc_next;
  logic [PW-1:0]  rtop, rtop_next;
  logic [PW-1:0]  pc, pc_next;
  logic [32:0]    steps, steps_next;
  logic           halted, halted_next;
  logic [3:0]     stop_st, stop_st_next;
  logic [2:0]     fill, fill_next;

  // memories
  logic [7:0]    smem [STACK_DEPTH];
  logic [PW-1:0] rmem [CALL_DEPTH];
  logic [7:0]    dmem [bsme_pkg::DATA_MEM_BYTES];
  logic [bsme_pkg::DATA_MEM_BYTES-1:0] dvld;
  logic [7:0]    s_rd, d_rd;
  logic [PW-1:0] r_rd;
  logic          d_rd_vld;

  logic           s_we, r_we, d_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [RAW-1:0] r_waddr, r_raddr;
  logic [7:0]     s_wdata;

  logic          accept, fifo_full, taken, ov;
  logic [7:0]    ob;
  logic [3:0]    st;
  logic [PW-1:0] len, pc1;
  logic          has_opnd;
  logic [SCW-1:0] sc_m1, sc_m2;
  bsme_pkg::result_t rslt;

  assign cfg_ready = !rst;
  assign item_stall = rst || (fill != F_IDLE) || fifo_full;
  assign accept = item_valid && !item_stall;

  assign len = (code_size > LIMIT) ? LIMIT : code_size;
  assign pc1 = pc + PW'(1);
  assign has_opnd = ({1'b0, pc} + {{PW{1'b0}}, 1'b1}) < {1'b0, len};
  assign sc_m1 = sc - SCW'(1);
  assign sc_m2 = sc - SCW'(2);

  always_comb begin
    sc_next = sc;
    tos_next = tos;
    nos_next = nos;
    rc_next = rc;
    rtop_next = rtop;
    pc_next = pc;
    steps_next = steps;
    halted_next = halted;
    stop_st_next = stop_st;
    fill_next = fill;
    st = bsme_pkg::ST_RUN;
    ov = 1'b0;
    ob = 8'd0;
    taken = 1'b0;
    s_we = 1'b0;
    s_waddr = sc_m2[SAW-1:0];
    s_wdata = nos;
    s_raddr = sc_m2[SAW-1:0];
    r_we = 1'b0;
    r_waddr = RAW'(rc - RCW'(1));
    r_raddr = RAW'(rc - RCW'(2));
    d_we = 1'b0;

    case (fill)
      F_NOS: begin
        nos_next = s_rd;
        fill_next = F_IDLE;
      end
      F_TOS: begin
        tos_next = s_rd;
        // sc already holds the popped count; fetch the byte below
        s_raddr = sc_m2[SAW-1:0];
        fill_next = (sc >= SCW'(2)) ? F_NOS : F_IDLE;
      end
      F_LOAD: begin
        tos_next = d_rd_vld ? d_rd : 8'd0;
        fill_next = F_IDLE;
      end
      F_RET: begin
        rtop_next = r_rd;
        fill_next = F_IDLE;
      end
      default: ;
    endcase

    if (accept) begin
      if (halted) begin
        st = stop_st;
      end else if (steps >= {1'b0, step_budget}) begin
        st = bsme_pkg::ST_STEPS;
      end else if (pc >= len) begin
        steps_next = steps + 33'd1;
        st = bsme_pkg::ST_PC;
      end else begin
        steps_next = steps + 33'd1;
        pc_next = pc1;
        case (item.opcode)
          bsme_pkg::OP_HALT: st = bsme_pkg::ST_HALT;
          bsme_pkg::OP_PUSH, bsme_pkg::OP_IN, bsme_pkg::OP_DUP: begin
            if (item.opcode == bsme_pkg::OP_PUSH && !has_opnd) begin
              st = bsme_pkg::ST_OPND;
            end else if (item.opcode == bsme_pkg::OP_IN && !item.in_valid) begin
              st = bsme_pkg::ST_INPUT;
            end else if (item.opcode == bsme_pkg::OP_DUP && sc == SCW'(0)) begin
              st = bsme_pkg::ST_UNF;
            end else begin
              if (item.opcode == bsme_pkg::OP_PUSH) pc_next = pc1 + PW'(1);
              if (item.opcode == bsme_pkg::OP_IN) taken = 1'b1;
              if (sc == SCW'(STACK_DEPTH)) begin
                st = bsme_pkg::ST_OVF;
              end else begin
                s_we = (sc >= SCW'(2));
                nos_next = tos;
                case (item.opcode)
                  bsme_pkg::OP_PUSH: tos_next = item.operand;
                  bsme_pkg::OP_IN:   tos_next = item.in_byte;
                  default:           tos_next = tos;
                endcase
                sc_next = sc + SCW'(1);
              end
            end
          end
          bsme_pkg::OP_DROP, bsme_pkg::OP_DROP2, bsme_pkg::OP_OUT,
          bsme_pkg::OP_BZ: begin
            if (sc == SCW'(0) || (item.opcode == bsme_pkg::OP_BZ && !has_opnd)) begin
              st = bsme_pkg::ST_UNF;
            end else begin
              if (item.opcode == bsme_pkg::OP_OUT) begin
                ov = 1'b1;
                ob = tos;
              end
              if (item.opcode == bsme_pkg::OP_BZ) begin
                pc_next = (tos == 8'd0) ? PW'(item.operand) : pc1 + PW'(1);
              end
              tos_next = nos;
              sc_next = sc_m1;
              // old count minus three is the new second entry
              s_raddr = SAW'(sc - SCW'(3));
              fill_next = (sc_m1 >= SCW'(2)) ? F_NOS : F_IDLE;
            end
          end
          bsme_pkg::OP_ADD, bsme_pkg::OP_SUB, bsme_pkg::OP_EQ, bsme_pkg::OP_LT,
          bsme_pkg::OP_AND, bsme_pkg::OP_OR, bsme_pkg::OP_XOR: begin
            if (sc < SCW'(2)) begin
              st = bsme_pkg::ST_UNF;
            end else begin
              case (item.opcode)
                bsme_pkg::OP_ADD: tos_next = nos + tos;
                bsme_pkg::OP_SUB: tos_next = nos - tos;
                bsme_pkg::OP_EQ:  tos_next = {7'd0, nos == tos};
                bsme_pkg::OP_LT:  tos_next = {7'd0, nos < tos};
                bsme_pkg::OP_AND: tos_next = nos & tos;
                bsme_pkg::OP_OR:  tos_next = nos | tos;
                default:          tos_next = nos ^ tos;
              endcase
              sc_next = sc_m1;
              s_raddr = SAW'(sc - SCW'(3));
              fill_next = (sc_m1 >= SCW'(2)) ? F_NOS : F_IDLE;
            end
          end
          bsme_pkg::OP_LOAD: begin
            if (sc == SCW'(0)) st = bsme_pkg::ST_UNF;
            else fill_next = F_LOAD;
          end
          bsme_pkg::OP_STORE: begin
            if (sc < SCW'(2)) begin
              st = bsme_pkg::ST_UNF;
            end else begin
              d_we = 1'b1;
              sc_next = sc_m2;
              s_raddr = SAW'(sc - SCW'(3));
              fill_next = (sc_m2 >= SCW'(1)) ? F_TOS : F_IDLE;
            end
          end
          bsme_pkg::OP_JMP: begin
            if (!has_opnd) st = bsme_pkg::ST_OPND;
            else pc_next = PW'(item.operand);
          end
          bsme_pkg::OP_CALL: begin
            if (!has_opnd) begin
              st = bsme_pkg::ST_OPND;
            end else if (rc >= RCW'(CALL_DEPTH)) begin
              st = bsme_pkg::ST_COVF;
            end else begin
              r_we = (rc >= RCW'(1));
              rtop_next = pc1 + PW'(1);
              rc_next = rc + RCW'(1);
              pc_next = PW'(item.operand);
            end
          end
          bsme_pkg::OP_RET: begin
            if (rc == RCW'(0)) begin
              st = bsme_pkg::ST_RUNF;
            end else begin
              pc_next = rtop;
              rc_next = rc - RCW'(1);
              fill_next = (rc >= RCW'(2)) ? F_RET : F_IDLE;
            end
          end
          default: st = bsme_pkg::ST_BADOP;
        endcase
      end
      if (!halted && st != bsme_pkg::ST_RUN) begin
        halted_next = 1'b1;
        stop_st_next = st;
      end
    end
  end

  always_comb begin
    rslt.status = st;
    rslt.next_pc = pc_next;
    rslt.out_valid = ov;
    rslt.out_byte = ob;
    rslt.input_taken = taken;
    rslt.stopped = halted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_size <= '0;
      step_budget <= bsme_pkg::STEPS_RESET;
      sc <= '0;
      rc <= '0;
      pc <= '0;
      steps <= '0;
      halted <= 1'b0;
      stop_st <= bsme_pkg::ST_RUN;
      fill <= F_IDLE;
      dvld <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bsme_pkg::REG_CODE_LENGTH) code_size <= cfg_data[PW-1:0];
        else if (cfg_index == bsme_pkg::REG_MAX_STEPS) step_budget <= cfg_data;
      end
      sc <= sc_next;
      rc <= rc_next;
      pc <= pc_next;
      steps <= steps_next;
      halted <= halted_next;
      stop_st <= stop_st_next;
      fill <= fill_next;
      if (d_we) dvld[tos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
    nos <= nos_next;
    rtop <= rtop_next;
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    s_rd <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) rmem[r_waddr] <= rtop;
    r_rd <= rmem[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (d_we) dmem[tos] <= nos;
    d_rd <= dmem[tos];
    d_rd_vld <= dvld[tos];
  end

  bsme_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .wr        (accept),
    .din       (rslt),
    .full      (fifo_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
`default_nettype wire

[hw/rtl/bsme_checker.sv]
// ----------------------------------------------------------------------------
// bsme_checker
// Port-level checks on the executor's results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module bsme_checker (
  input wire               clk,
  input wire               rst,
  input wire               res_valid,
  input wire               res_stall,
  input bsme_pkg::result_t res
);

  `ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
  `ASSERT_IMPL(a_stop_status, res_valid, res.stopped == (res.status != bsme_pkg::ST_RUN))
  `ASSERT_IMPL(a_out_running, res_valid && res.out_valid, res.status == bsme_pkg::ST_RUN)
  `ASSERT_IMPL(a_taken_ok, res_valid && res.input_taken,
               res.status == bsme_pkg::ST_RUN || res.status == bsme_pkg::ST_OVF)

endmodule

bind byte_stack_machine_executor_unit bsme_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte stack machine executor: a scoreboard model
// runs each instruction as it is queued, and the monitor compares every result
// transaction against it. Programs stay fault-free until a final fault stops
// the machine.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // small stacks and code window so the limits are reachable
  localparam int DEPTH = 16;
  localparam int CDEPTH = 4;
  localparam int CLIMIT = 256;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  bsme_pkg::item_t item = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  bsme_pkg::result_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  byte_stack_machine_executor_unit #(
    .STACK_DEPTH(DEPTH),
    .CALL_DEPTH(CDEPTH),
    .CODE_LIMIT(CLIMIT)
  ) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // machine state mirror
  logic [7:0] dstk [DEPTH];
  logic [20:0] rstk [CDEPTH];
  logic [7:0] dmem [256];
  int dcount, rcount;
  logic [20:0] pc_m;
  longint unsigned steps;
  logic halted;
  logic [3:0] stop_st;
  logic [20:0] code_size;
  logic [31:0] max_st;

  bsme_pkg::item_t item_q[$];
  bsme_pkg::result_t result_q[$];
  int errs = 0;
  int cyc = 0;

  function automatic int eff_len();
    return (code_size > CLIMIT) ? CLIMIT : int'(code_size);
  endfunction

  function automatic logic [7:0] alu(logic [7:0] op, logic [7:0] a, logic [7:0] b);
    case (op)
      bsme_pkg::OP_ADD: return a + b;
      bsme_pkg::OP_SUB: return a - b;
      bsme_pkg::OP_EQ: return {7'd0, a == b};
      bsme_pkg::OP_LT: return {7'd0, a < b};
      bsme_pkg::OP_AND: return a & b;
      bsme_pkg::OP_OR: return a | b;
      default: return a ^ b;
    endcase
  endfunction

  function automatic bsme_pkg::result_t run_insn(bsme_pkg::item_t it);
    bsme_pkg::result_t r;
    int len;
    logic [3:0] st;
    logic [20:0] pc;
    logic has_opnd;
    logic [7:0] a, b;
    r = '0;
    len = eff_len();
    st = bsme_pkg::ST_RUN;
    pc = pc_m;
    if (halted) begin
      r.status = stop_st;
      r.next_pc = pc_m;
      r.stopped = 1'b1;
      return r;
    end
    if (steps >= max_st) st = bsme_pkg::ST_STEPS;
    else if (int'(pc) >= len) begin
      steps++;
      st = bsme_pkg::ST_PC;
    end else begin
      steps++;
      has_opnd = (int'(pc) + 1) < len;
      pc = pc + 21'd1;
      case (it.opcode)
        bsme_pkg::OP_HALT: st = bsme_pkg::ST_HALT;
        bsme_pkg::OP_PUSH: begin
          if (!has_opnd) st = bsme_pkg::ST_OPND;
          else begin
            pc = pc + 21'd1;
            if (dcount >= DEPTH) st = bsme_pkg::ST_OVF;
            else begin dstk[dcount] = it.operand; dcount++; end
          end
        end
        bsme_pkg::OP_DROP, bsme_pkg::OP_DROP2, bsme_pkg::OP_OUT: begin
          if (dcount == 0) st = bsme_pkg::ST_UNF;
          else begin
            dcount--;
            if (it.opcode == bsme_pkg::OP_OUT) begin
              r.out_valid = 1'b1;
              r.out_byte = dstk[dcount];
            end
          end
        end
        bsme_pkg::OP_ADD, bsme_pkg::OP_SUB, bsme_pkg::OP_EQ, bsme_pkg::OP_LT,
        bsme_pkg::OP_AND, bsme_pkg::OP_OR, bsme_pkg::OP_XOR: begin
          if (dcount < 2) st = bsme_pkg::ST_UNF;
          else begin
            b = dstk[dcount-1];
            a = dstk[dcount-2];
            dcount--;
            dstk[dcount-1] = alu(it.opcode, a, b);
          end
        end
        bsme_pkg::OP_LOAD: begin
          if (dcount == 0) st = bsme_pkg::ST_UNF;
          else dstk[dcount-1] = dmem[dstk[dcount-1]];
        end
        bsme_pkg::OP_STORE: begin
          if (dcount < 2) st = bsme_pkg::ST_UNF;
          else begin
            a = dstk[dcount-1];
            b = dstk[dcount-2];
            dcount -= 2;
            dmem[a] = b;
          end
        end
        bsme_pkg::OP_JMP: begin
          if (!has_opnd) st = bsme_pkg::ST_OPND;
          else pc = {13'd0, it.operand};
        end
        bsme_pkg::OP_BZ: begin
          if (dcount == 0 || !has_opnd) st = bsme_pkg::ST_UNF;
          else begin
            dcount--;
            pc = pc + 21'd1;
            if (dstk[dcount] == 8'd0) pc = {13'd0, it.operand};
          end
        end
        bsme_pkg::OP_CALL: begin
          if (!has_opnd) st = bsme_pkg::ST_OPND;
          else if (rcount >= CDEPTH) st = bsme_pkg::ST_COVF;
          else begin
            rstk[rcount] = pc + 21'd1;
            rcount++;
            pc = {13'd0, it.operand};
          end
        end
        bsme_pkg::OP_RET: begin
          if (rcount == 0) st = bsme_pkg::ST_RUNF;
          else begin rcount--; pc = rstk[rcount]; end
        end
        bsme_pkg::OP_IN: begin
          if (!it.in_valid) st = bsme_pkg::ST_INPUT;
          else begin
            r.input_taken = 1'b1;
            if (dcount >= DEPTH) st = bsme_pkg::ST_OVF;
            else begin dstk[dcount] = it.in_byte; dcount++; end
          end
        end
        bsme_pkg::OP_DUP: begin
          if (dcount == 0) st = bsme_pkg::ST_UNF;
          else if (dcount >= DEPTH) st = bsme_pkg::ST_OVF;
          else begin dstk[dcount] = dstk[dcount-1]; dcount++; end
        end
        default: st = bsme_pkg::ST_BADOP;
      endcase
    end
    pc_m = pc;
    if (st != bsme_pkg::ST_RUN) begin
      halted = 1'b1;
      stop_st = st;
    end
    r.status = st;
    r.next_pc = pc_m;
    r.stopped = halted;
    return r;
  endfunction

  task automatic issue(logic [7:0] op, logic [7:0] opnd, logic [7:0] ib, logic iv);
    bsme_pkg::item_t it;
    it.opcode = op;
    it.operand = opnd;
    it.in_byte = ib;
    it.in_valid = iv;
    result_q.push_back(run_insn(it));
    item_q.push_back(it);
  endtask

  function automatic logic [7:0] rnd_target();
    int hi;
    hi = eff_len() - 2;
    if (hi > 255) hi = 255;
    return 8'($urandom_range(0, hi));
  endfunction

  // keeps pc <= len-2 so a jump can always be fetched with its operand
  task automatic rand_insn();
    logic [7:0] op;
    logic ok;
    if (int'(pc_m) + 4 > eff_len()) begin
      issue(bsme_pkg::OP_JMP, rnd_target(), 8'($urandom_range(0, 255)),
            1'($urandom_range(0, 1)));
      return;
    end
    ok = 1'b0;
    while (!ok) begin
      op = 8'($urandom_range(1, 19));
      case (op)
        bsme_pkg::OP_PUSH, bsme_pkg::OP_IN: ok = dcount < DEPTH;
        bsme_pkg::OP_DUP: ok = dcount > 0 && dcount < DEPTH;
        bsme_pkg::OP_DROP, bsme_pkg::OP_DROP2, bsme_pkg::OP_OUT, bsme_pkg::OP_LOAD,
        bsme_pkg::OP_BZ: ok = dcount > 0;
        bsme_pkg::OP_CALL: ok = rcount < CDEPTH;
        // return addresses left from a wider code window are not taken
        bsme_pkg::OP_RET: ok = rcount > 0 && int'(rstk[rcount-1]) + 2 <= eff_len();
        bsme_pkg::OP_JMP: ok = 1'b1;
        default: ok = dcount >= 2;
      endcase
    end
    if (op == bsme_pkg::OP_JMP || op == bsme_pkg::OP_BZ || op == bsme_pkg::OP_CALL)
      issue(op, rnd_target(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    else
      issue(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            (op == bsme_pkg::OP_IN) ? 1'b1 : 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    while (item_q.size() > 0 || result_q.size() > 0 || item_valid) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bsme_pkg::REG_CODE_LENGTH) code_size = data[20:0];
    else if (idx == bsme_pkg::REG_MAX_STEPS) max_st = data;
  endtask

  task automatic phase(logic [31:0] len, logic [31:0] steps_cap, int n);
    // park at address 0 before the code window can shrink under pc
    issue(bsme_pkg::OP_JMP, 8'd0, 8'd0, 1'b0);
    drain();
    cfg_write(bsme_pkg::REG_CODE_LENGTH, len);
    cfg_write(bsme_pkg::REG_MAX_STEPS, steps_cap);
    repeat (n) rand_insn();
  endtask

  // drives the machine into one fault chosen at random
  task automatic stop_machine();
    int kind;
    kind = $urandom_range(0, 10);
    case (kind)
      0: issue(bsme_pkg::OP_HALT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               1'b1);
      1: issue(8'($urandom_range(20, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 1'b1);
      2: begin
        while (dcount < DEPTH && !halted) begin
          if (int'(pc_m) + 4 > eff_len()) issue(bsme_pkg::OP_JMP, 8'd0, 8'd0, 1'b0);
          else issue(bsme_pkg::OP_PUSH, 8'($urandom_range(0, 255)), 8'd0, 1'b0);
        end
        if (int'(pc_m) + 4 > eff_len()) issue(bsme_pkg::OP_JMP, 8'd0, 8'd0, 1'b0);
        case ($urandom_range(0, 2))
          0: issue(bsme_pkg::OP_PUSH, 8'd1, 8'd0, 1'b0);
          1: issue(bsme_pkg::OP_IN, 8'd0, 8'($urandom_range(0, 255)), 1'b1);
          default: issue(bsme_pkg::OP_DUP, 8'd0, 8'd0, 1'b0);
        endcase
      end
      3: begin
        while (dcount > 0 && !halted) begin
          if (int'(pc_m) + 4 > eff_len()) issue(bsme_pkg::OP_JMP, 8'd0, 8'd0, 1'b0);
          else issue(bsme_pkg::OP_DROP, 8'd0, 8'd0, 1'b0);
        end
        if (int'(pc_m) + 4 > eff_len()) issue(bsme_pkg::OP_JMP, 8'd0, 8'd0, 1'b0);
        case ($urandom_range(0, 4))
          0: issue(bsme_pkg::OP_ADD, 8'd0, 8'd0, 1'b0);
          1: issue(bsme_pkg::OP_STORE, 8'd0, 8'd0, 1'b0);
          2: issue(bsme_pkg::OP_OUT, 8'd0, 8'd0, 1'b0);
          3: issue(bsme_pkg::OP_BZ, 8'd0, 8'd0, 1'b0);
          default: issue(bsme_pkg::OP_LOAD, 8'd0, 8'd0, 1'b0);
        endcase
      end
      4: begin
        while (rcount <= CDEPTH) begin
          if (int'(pc_m) + 4 > eff_len()) issue(bsme_pkg::OP_JMP, 8'd0, 8'd0, 1'b0);
          else issue(bsme_pkg::OP_CALL, rnd_target(), 8'd0, 1'b0);
          if (halted) break;
        end
      end
      5: begin
        while (!halted) begin
          if (int'(pc_m) + 4 > eff_len()) issue(bsme_pkg::OP_JMP, 8'd0, 8'd0, 1'b0);
          else issue(bsme_pkg::OP_RET, 8'd0, 8'd0, 1'b0);
        end
      end
      6: issue(bsme_pkg::OP_IN, 8'd0, 8'($urandom_range(0, 255)), 1'b0);
      7: begin
        drain();
        cfg_write(bsme_pkg::REG_CODE_LENGTH, {11'd0, pc_m});
        issue(bsme_pkg::OP_PUSH, 8'd1, 8'd0, 1'b0);
      end
      8: begin
        drain();
        cfg_write(bsme_pkg::REG_MAX_STEPS,
                  ($urandom_range(0, 1) == 0) ? 32'd0 : 32'(steps));
        issue(bsme_pkg::OP_PUSH, 8'd1, 8'd0, 1'b0);
      end
      9: begin
        drain();
        cfg_write(bsme_pkg::REG_CODE_LENGTH, {11'd0, pc_m} + 32'd1);
        issue(($urandom_range(0, 2) == 0) ? bsme_pkg::OP_PUSH :
              ($urandom_range(0, 1) == 0) ? bsme_pkg::OP_JMP : bsme_pkg::OP_CALL,
              8'd3, 8'd0, 1'b0);
      end
      default: begin
        if (dcount == 0) issue(bsme_pkg::OP_PUSH, 8'd0, 8'd0, 1'b0);
        issue(bsme_pkg::OP_JMP, 8'd0, 8'd0, 1'b0);
        drain();
        cfg_write(bsme_pkg::REG_CODE_LENGTH, 32'd1);
        issue(bsme_pkg::OP_BZ, 8'd5, 8'd0, 1'b0);
      end
    endcase
    // later transactions are ignored by a stopped machine
    repeat (30) issue(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // driver
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        item <= item_q.pop_front();
        item_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result stall pattern
  int stall_mode = 0;
  int mode_left = 0;
  int tick = 0;
  always @(posedge clk) begin
    tick++;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else mode_left--;
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= tick[2];
        default: res_stall <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    bsme_pkg::result_t e;
    if (!rst && res_valid && !res_stall) begin
      if (result_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errs++;
      end else begin
        e = result_q.pop_front();
        if (res.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, res.status); errs++;
        end
        if (res.next_pc !== e.next_pc) begin
          $error("next_pc exp %0d got %0d", e.next_pc, res.next_pc); errs++;
        end
        if (res.out_valid !== e.out_valid) begin
          $error("out_valid exp %0d got %0d", e.out_valid, res.out_valid); errs++;
        end
        if (res.out_byte !== e.out_byte) begin
          $error("out_byte exp %0d got %0d", e.out_byte, res.out_byte); errs++;
        end
        if (res.input_taken !== e.input_taken) begin
          $error("input_taken exp %0d got %0d", e.input_taken, res.input_taken); errs++;
        end
        if (res.stopped !== e.stopped) begin
          $error("stopped exp %0d got %0d", e.stopped, res.stopped); errs++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    dcount = 0;
    rcount = 0;
    pc_m = '0;
    steps = 0;
    halted = 1'b0;
    stop_st = bsme_pkg::ST_RUN;
    code_size = '0;
    max_st = bsme_pkg::STEPS_RESET;
    foreach (dmem[i]) dmem[i] = 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // oversized length folds down to the code window
    cfg_write(bsme_pkg::REG_CODE_LENGTH, 32'hFFFF_FFFF);
    issue(bsme_pkg::OP_PUSH, 8'd255, 8'd0, 1'b0);
    issue(bsme_pkg::OP_PUSH, 8'd0, 8'd255, 1'b1);
    issue(bsme_pkg::OP_ADD, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_IN, 8'd255, 8'd0, 1'b1);
    issue(bsme_pkg::OP_SUB, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_DUP, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_EQ, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_PUSH, 8'd3, 8'd0, 1'b0);
    issue(bsme_pkg::OP_LT, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_IN, 8'd0, 8'd255, 1'b1);
    issue(bsme_pkg::OP_AND, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_PUSH, 8'hAA, 8'd0, 1'b0);
    issue(bsme_pkg::OP_OR, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_PUSH, 8'h55, 8'd0, 1'b0);
    issue(bsme_pkg::OP_XOR, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_PUSH, 8'd9, 8'd0, 1'b0);
    issue(bsme_pkg::OP_STORE, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_PUSH, 8'd9, 8'd0, 1'b0);
    issue(bsme_pkg::OP_LOAD, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_DUP, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_OUT, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_CALL, 8'd100, 8'd0, 1'b0);
    issue(bsme_pkg::OP_RET, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_PUSH, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_BZ, 8'd40, 8'd0, 1'b0);
    issue(bsme_pkg::OP_DROP2, 8'd0, 8'd0, 1'b0);
    issue(bsme_pkg::OP_JMP, 8'd10, 8'd0, 1'b0);
    repeat (200) rand_insn();
    phase(32'd256, 32'hFFFF_FFFF, 250);
    phase(32'd40, bsme_pkg::STEPS_RESET, 250);
    phase(32'd4, 32'hFFFF_FFFF, 100);
    phase(32'd200, 32'd1_000_000, 250);
    phase(32'd17, bsme_pkg::STEPS_RESET, 150);
    stop_machine();
    drain();
    repeat (20) @(posedge clk);
    if (errs == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/bsme_pkg.sv
hw/rtl/bsme_out_fifo.sv
hw/rtl/byte_stack_machine_executor_unit.sv
hw/rtl/bsme_checker.sv
test/tb.sv
